// ----- rtl/imhsq_pkg.sv -----
`default_nettype none
package imhsq_pkg;
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_EXTRACT = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_UPDATE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam int ID_W  = 6;
    localparam int KEY_W = 5;
    localparam int ENT_W = ID_W + KEY_W;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;
endpackage
`default_nettype wire

// ----- rtl/imhsq_ram.sv -----
`default_nettype none
module imhsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/indexed_min_heap_scheduler_queue_unit.sv -----
// channel | direction | signals
// in      | input     | i_valid, o_ready, i_kind, i_proc_id, i_burst_time
// out     | output    | o_valid, i_ready, o_out_id, o_out_burst, o_status, o_count
// one transaction at a time; a sift down steps through DNL, DNR and DNCMP per heap level
// and a sift up through UPRD and UPCMP, set by the single read port of the heap memory
// a clearing pass zeroes every position map entry after reset, input stalls meanwhile
// result is held in an output register until taken; the next transaction is accepted
// meanwhile and stalls in its last cycle only if its result is ready before that one is taken
`default_nettype none
module indexed_min_heap_scheduler_queue_unit
    import imhsq_pkg::*;
#(
    parameter int NUM_PROCS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_kind,
    input  wire [5:0]   i_proc_id,
    input  wire [4:0]   i_burst_time,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [5:0]  o_out_id,
    output logic [4:0]  o_out_burst,
    output logic [1:0]  o_status,
    output logic [6:0]  o_count
);
    localparam int AW = $clog2(NUM_PROCS + 1);   // heap position width (1-based)
    localparam int IW = $clog2(NUM_PROCS);
    localparam int HD = 1 << AW;

    localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_PMR = 5'd2, S_DEC = 5'd3,
        S_ROOT = 5'd5, S_LAST = 5'd7,
        S_CHK = 5'd9, S_UPRD = 5'd11, S_UPCMP = 5'd12,
        S_DNL = 5'd13, S_DNR = 5'd14, S_DNCMP = 5'd15, S_INS = 5'd16,
        S_DONE = 5'd17, S_DUP = 5'd20;

    logic [4:0] r_st, n_st;
    logic [AW-1:0] r_clr;
    logic [1:0] r_kind;
    logic [5:0] r_id;
    logic [4:0] r_key;
    logic [AW-1:0] r_size;   // heap size
    logic [AW-1:0] r_pos;    // current sift position
    t_entry r_cur;           // entry being sifted
    t_entry r_lch;
    logic [5:0] r_oid;
    logic [4:0] r_okey;
    logic [1:0] r_ost;
    logic r_ins_after;
    logic r_ovalid;
    logic [5:0] r_res_id;
    logic [4:0] r_res_key;
    logic [1:0] r_res_st;
    logic [6:0] r_res_cnt;
    logic res_load;

    // heap memory
    logic h_we;
    logic [AW-1:0] h_wa, h_ra;
    t_entry h_wd, h_rd;
    // position memory
    logic p_we;
    logic [IW-1:0] p_wa, p_ra;
    logic [AW-1:0] p_wd, p_rd;

    imhsq_ram #(.WIDTH(ENT_W), .DEPTH(HD)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));
    imhsq_ram #(.WIDTH(AW), .DEPTH(NUM_PROCS)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));

    logic id_ok;
    assign id_ok = ({26'd0, r_id} < 32'(NUM_PROCS));
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out_id = r_res_id;
    assign o_out_burst = r_res_key;
    assign o_status = r_res_st;
    assign o_count = r_res_cnt;

    logic [AW-1:0] n_pos, n_size, parent, lchild;
    t_entry n_cur, n_lch;
    logic [5:0] n_oid;
    logic [4:0] n_okey;
    logic [1:0] n_ost;
    logic n_ins_after, n_ovalid;
    logic [AW:0] lc_w;
    assign parent = r_pos >> 1;
    assign lc_w = {r_pos, 1'b0};

    always_comb begin
        n_st = r_st; n_pos = r_pos; n_size = r_size; n_cur = r_cur; n_lch = r_lch;
        n_oid = r_oid; n_okey = r_okey; n_ost = r_ost; n_ins_after = r_ins_after;
        n_ovalid = r_ovalid; res_load = 1'b0;
        h_we = 1'b0; h_wa = r_pos; h_wd = r_cur; h_ra = r_pos;
        p_we = 1'b0; p_wa = r_cur.id[IW-1:0]; p_wd = r_pos; p_ra = r_id[IW-1:0];
        lchild = lc_w[AW-1:0];
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_st)
            S_CLR: begin
                p_we = 1'b1; p_wa = r_clr[IW-1:0]; p_wd = '0;
                if (32'(r_clr) == NUM_PROCS - 1) n_st = S_IDLE;
            end
            S_IDLE: begin
                p_ra = i_proc_id[IW-1:0];
                if (i_valid && o_ready) n_st = S_PMR;
            end
            S_PMR: begin
                n_st = S_DEC;
            end
            S_DEC: begin
                n_oid = r_id; n_okey = '0; n_ost = ST_OK; n_ins_after = 1'b0;
                case (r_kind)
                    KIND_EXTRACT: begin
                        if (r_size == '0) begin
                            n_oid = '0; n_ost = ST_EMPTY; n_st = S_DONE;
                        end else begin
                            n_pos = AW'(1); h_ra = AW'(1); n_st = S_ROOT;
                        end
                    end
                    KIND_INSERT: begin
                        if (!id_ok) begin
                            n_ost = ST_ABSENT; n_st = S_DONE;
                        end else if (p_rd != '0) begin
                            n_ost = ST_DUP; h_ra = p_rd; n_st = S_DUP;
                        end else begin
                            n_st = S_INS;
                        end
                    end
                    default: begin
                        if (!id_ok || p_rd == '0 || p_rd > r_size) begin
                            n_ost = ST_ABSENT; n_st = S_DONE;
                        end else begin
                            n_pos = p_rd; h_ra = p_rd; n_st = S_ROOT;
                            n_ins_after = (r_kind == KIND_UPDATE);
                        end
                    end
                endcase
            end
            S_DUP: begin
                n_okey = h_rd.key; n_st = S_DONE;
            end
            S_ROOT: begin
                // h_rd is the entry being removed
                if (r_kind == KIND_EXTRACT) n_oid = h_rd.id;
                if (r_kind != KIND_UPDATE) n_okey = h_rd.key;
                p_we = 1'b1; p_wa = h_rd.id[IW-1:0]; p_wd = '0;
                h_ra = r_size;
                n_st = S_LAST;
            end
            S_LAST: begin
                n_cur = h_rd;
                n_size = r_size - 1'b1;
                if (r_pos == r_size) begin
                    n_st = S_DONE;
                end else begin
                    h_ra = parent;
                    n_st = S_CHK;
                end
            end
            S_CHK: begin
                // h_rd is parent of hole (if any)
                h_ra = parent;
                if (r_pos > AW'(1) && h_rd.key > r_cur.key) begin
                    n_st = S_UPCMP;
                end else begin
                    n_st = S_DNL;
                end
            end
            S_INS: begin
                n_size = r_size + 1'b1;
                n_pos = r_size + 1'b1;
                n_cur = '{id: r_id, key: r_key};
                n_okey = r_key;
                n_st = S_UPRD;
            end
            S_UPRD: begin
                if (r_pos == AW'(1)) begin
                    h_we = 1'b1; p_we = 1'b1; n_st = S_DONE;
                end else begin
                    h_ra = parent; n_st = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (h_rd.key > r_cur.key) begin
                    h_we = 1'b1; h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd.id[IW-1:0]; p_wd = r_pos;
                    n_pos = parent; n_st = S_UPRD;
                end else begin
                    h_we = 1'b1; p_we = 1'b1; n_st = S_DONE;
                end
            end
            S_DNL: begin
                if (lc_w > {1'b0, r_size}) begin
                    h_we = 1'b1; p_we = 1'b1; n_st = S_DONE;
                end else begin
                    h_ra = lchild; n_st = S_DNR;
                end
            end
            S_DNR: begin
                n_lch = h_rd;
                h_ra = lchild + 1'b1;
                n_st = S_DNCMP;
            end
            S_DNCMP: begin
                if ((lc_w + 1'b1 <= {1'b0, r_size}) && h_rd.key < r_lch.key
                    && h_rd.key < r_cur.key) begin
                    h_we = 1'b1; h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd.id[IW-1:0]; p_wd = r_pos;
                    n_pos = lchild + 1'b1; n_st = S_DNL;
                end else if (r_lch.key < r_cur.key) begin
                    h_we = 1'b1; h_wd = r_lch;
                    p_we = 1'b1; p_wa = r_lch.id[IW-1:0]; p_wd = r_pos;
                    n_pos = lchild; n_st = S_DNL;
                end else begin
                    h_we = 1'b1; p_we = 1'b1; n_st = S_DONE;
                end
            end
            S_DONE: begin
                if (r_ins_after) begin
                    n_ins_after = 1'b0; n_st = S_INS;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1; res_load = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_size <= '0; r_ovalid <= 1'b0;
            r_ins_after <= 1'b0;
        end else begin
            r_st <= n_st; r_size <= n_size; r_ovalid <= n_ovalid;
            r_ins_after <= n_ins_after;
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid && o_ready) begin
            r_kind <= i_kind; r_id <= i_proc_id; r_key <= i_burst_time;
        end
        if (res_load) begin
            r_res_id <= r_oid; r_res_key <= r_okey; r_res_st <= r_ost;
            r_res_cnt <= 7'(r_size);
        end
        r_pos <= n_pos; r_cur <= n_cur; r_lch <= n_lch;
        r_oid <= n_oid; r_okey <= n_okey; r_ost <= n_ost;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_count))
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_id) && $stable(o_out_burst)
            && $stable(o_status))
        else $error("result changed while held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_size) <= NUM_PROCS)
        else $error("size overflow");
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
    import imhsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 64;
    localparam int STALL_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_kind;
    logic [5:0] i_proc_id;
    logic [4:0] i_burst_time;
    logic       o_valid;
    logic       i_ready;
    logic [5:0] o_out_id;
    logic [4:0] o_out_burst;
    logic [1:0] o_status;
    logic [6:0] o_count;

    indexed_min_heap_scheduler_queue_unit #(.NUM_PROCS(NPROC)) dut (.*);

    typedef struct packed {
        logic [5:0] id;
        logic [4:0] burst;
        logic [1:0] status;
        logic [6:0] count;
    } t_sched_result;

    t_entry        heap_model [1:NPROC];
    int unsigned   pos_model [NPROC];
    int unsigned   size_model;
    t_sched_result pending_results [$];

    int  errors = 0;
    int  idle_cycles = 0;
    int  sent = 0;
    int  received = 0;
    int  ok_count = 0;
    int  special_count = 0;
    bit  hold_off = 0;
    bit  rx_done_stall = 0;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ---------------- heap predictor ----------------
    function automatic void put_entry(int unsigned p, t_entry e);
        heap_model[p] = e;
        pos_model[e.id] = p;
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        t_entry ea;
        t_entry eb;
        ea = heap_model[a];
        eb = heap_model[b];
        put_entry(a, eb);
        put_entry(b, ea);
    endfunction

    function automatic void bubble_up(int unsigned p);
        while (p > 1 && heap_model[p/2].key > heap_model[p].key) begin
            swap_entries(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down(int unsigned p);
        int unsigned l;
        int unsigned best;
        forever begin
            l = 2 * p;
            best = p;
            if (l <= size_model && heap_model[l].key < heap_model[best].key) best = l;
            if (l + 1 <= size_model && heap_model[l+1].key < heap_model[best].key)
                best = l + 1;
            if (best == p) return;
            swap_entries(p, best);
            p = best;
        end
    endfunction

    function automatic void take_out(int unsigned p);
        logic [5:0] gone;
        gone = heap_model[p].id;
        if (p != size_model) swap_entries(p, size_model);
        pos_model[gone] = 0;
        size_model--;
        if (p <= size_model) begin
            if (p > 1 && heap_model[p/2].key > heap_model[p].key) bubble_up(p);
            else bubble_down(p);
        end
    endfunction

    function automatic void add_entry(logic [5:0] id, logic [4:0] key);
        t_entry e;
        e.id = id;
        e.key = key;
        size_model++;
        put_entry(size_model, e);
        bubble_up(size_model);
    endfunction

    function automatic t_sched_result schedule_step(logic [1:0] kind, logic [5:0] id,
                                                    logic [4:0] key);
        t_sched_result r;
        int unsigned p;
        r.id = id;
        r.burst = '0;
        r.status = ST_OK;
        p = pos_model[id];
        case (kind)
            KIND_EXTRACT: begin
                if (size_model == 0) begin
                    r.id = '0;
                    r.status = ST_EMPTY;
                end else begin
                    r.id = heap_model[1].id;
                    r.burst = heap_model[1].key;
                    take_out(1);
                end
            end
            KIND_INSERT: begin
                if (p != 0) begin
                    r.status = ST_DUP;
                    r.burst = heap_model[p].key;
                end else begin
                    add_entry(id, key);
                    r.burst = key;
                end
            end
            KIND_REMOVE: begin
                if (p == 0 || p > size_model) r.status = ST_ABSENT;
                else begin
                    r.burst = heap_model[p].key;
                    take_out(p);
                end
            end
            default: begin
                if (p == 0 || p > size_model) r.status = ST_ABSENT;
                else begin
                    take_out(p);
                    add_entry(id, key);
                    r.burst = key;
                end
            end
        endcase
        r.count = 7'(size_model);
        return r;
    endfunction

    // ---------------- sender ----------------
    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 45) n = 0;
        else if (n < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n != 0) i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_op(logic [1:0] kind, logic [5:0] id, logic [4:0] key);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_proc_id <= id;
        i_burst_time <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(schedule_step(kind, id, key));
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_gapped(logic [1:0] kind, logic [5:0] id, logic [4:0] key);
        send_op(kind, id, key);
        random_gap();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    // ---------------- receiver ----------------
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            n = $urandom_range(0, 99);
            if (n < 55) i_ready <= 1'b1;
            else if (n < 95) i_ready <= 1'b0;
            else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 50)) @(negedge i_clk);
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_sched_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            received++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result id=%0d burst=%0d status=%0d count=%0d",
                         $time, o_out_id, o_out_burst, o_status, o_count);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.status == ST_OK) ok_count++;
                else special_count++;
                if (o_out_id !== exp_r.id) begin
                    $display("%0t: out_id expected %0d actual %0d", $time, exp_r.id, o_out_id);
                    errors++;
                end
                if (o_out_burst !== exp_r.burst) begin
                    $display("%0t: out_burst expected %0d actual %0d",
                             $time, exp_r.burst, o_out_burst);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_count !== exp_r.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_r.count, o_count);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        send_gapped(KIND_EXTRACT, 6'd5, 5'd3);
        send_gapped(KIND_REMOVE, 6'd7, 5'd1);
        send_gapped(KIND_UPDATE, 6'd63, 5'd31);
        send_gapped(KIND_INSERT, 6'd0, 5'd20);
        send_gapped(KIND_INSERT, 6'd63, 5'd1);
        send_gapped(KIND_INSERT, 6'd42, 5'd31);
        send_gapped(KIND_INSERT, 6'd21, 5'd0);
        send_gapped(KIND_INSERT, 6'd10, 5'd20);
        send_gapped(KIND_INSERT, 6'd11, 5'd20);
        send_gapped(KIND_INSERT, 6'd63, 5'd7);
        send_gapped(KIND_UPDATE, 6'd42, 5'd2);
        send_gapped(KIND_UPDATE, 6'd21, 5'd31);
        send_gapped(KIND_REMOVE, 6'd63, 5'd0);
        send_gapped(KIND_REMOVE, 6'd63, 5'd0);
        send_gapped(KIND_EXTRACT, 6'd0, 5'd0);
        send_gapped(KIND_EXTRACT, 6'd0, 5'd0);
        send_gapped(KIND_REMOVE, 6'd10, 5'd0);
        send_gapped(KIND_EXTRACT, 6'd0, 5'd0);
        send_gapped(KIND_EXTRACT, 6'd0, 5'd0);
        send_gapped(KIND_EXTRACT, 6'd0, 5'd0);
        drain();
    endtask

    // fill every id, try a duplicate insert, then update, remove and extract until empty
    task automatic test_full_heap();
        int order [NPROC];
        int j;
        int t;
        for (int i = 0; i < NPROC; i++) order[i] = i;
        for (int i = NPROC - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i < NPROC; i++)
            send_gapped(KIND_INSERT, 6'(order[i]), 5'($urandom_range(1, 20)));
        send_gapped(KIND_INSERT, 6'(order[5]), 5'd9);
        for (int i = 0; i < 16; i++)
            send_gapped(KIND_UPDATE, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
        for (int i = 0; i < 32; i++)
            send_gapped(KIND_REMOVE, 6'($urandom_range(0, 63)), 5'($urandom));
        while (size_model != 0) send_gapped(KIND_EXTRACT, 6'($urandom), 5'($urandom));
        send_gapped(KIND_EXTRACT, 6'($urandom), 5'($urandom));
        drain();
    endtask

    // receiver held off while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 30; i++)
            send_op(KIND_INSERT, 6'($urandom_range(0, 63)), 5'($urandom_range(1, 20)));
        drain();
    endtask

    task automatic test_random(int count);
        int n;
        logic [1:0] kind;
        logic [4:0] key;
        for (int i = 0; i < count; i++) begin
            n = $urandom_range(0, 99);
            // keep the heap busy: favor inserts while small, extracts while large
            if (n < 50 - int'(size_model) / 2) kind = KIND_INSERT;
            else if (n < 75) kind = KIND_EXTRACT;
            else if (n < 88) kind = KIND_REMOVE;
            else kind = KIND_UPDATE;
            key = ($urandom_range(0, 19) == 0) ? 5'($urandom)
                                               : 5'($urandom_range(1, 20));
            send_gapped(kind, 6'($urandom_range(0, 63)), key);
            if (i % 400 == 399) drain();
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = '0;
        i_proc_id = '0;
        i_burst_time = '0;
        size_model = 0;
        for (int i = 0; i < NPROC; i++) pos_model[i] = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_full_heap();
        test_backpressure();
        test_random(1750);
        repeat (200) @(negedge i_clk);
        $display("sent %0d operations, checked %0d results", sent, received);
        $display("%0d completed normally, %0d refused as empty, duplicate or absent",
                 ok_count, special_count);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
